// File: rtl/opl_pkg.sv
// Package for the ordered pointer list: field widths, operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package opl_pkg;

   localparam int OP_W     = 3;
   localparam int POS_W    = 16;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int RPOS_W   = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_FIND   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_WRITE,
      S_DEL_WALK,
      S_GET_READ,
      S_GET_WAIT,
      S_SET_FILL,
      S_FIND_WALK,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_UP,
      WR_DOWN,
      WR_FILL,
      WR_WORD
   } wr_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_EXTEND
   } cnt_type;

   typedef struct packed {
      logic    load;
      logic    rd;
      logic    step;
      logic    down;
      logic    capture;
      logic    find;
      logic    emit;
      wr_type  wr;
      cnt_type cnt;
   } cmd_type;

   typedef struct packed {
      logic            req_skip;
      logic [OP_W-1:0] op;
      logic            idx_eq_pos;
      logic            idx_eq_count;
      logic            match;
      logic            last_miss;
      logic            out_free;
   } sts_type;

endpackage

// File: rtl/opl_ifs.sv
// Request and response channel interfaces of the ordered pointer list.
// Depends on opl_pkg.
interface opl_req_if;
   logic                         valid;
   logic                         ready;
   logic [opl_pkg::OP_W-1:0]     op;
   logic [opl_pkg::POS_W-1:0]    position;
   logic [opl_pkg::WORD_W-1:0]   data_word;

   modport source (output valid, output op, output position, output data_word, input ready);
   modport sink   (input valid, input op, input position, input data_word, output ready);
endinterface

interface opl_rsp_if;
   logic                         valid;
   logic                         ready;
   opl_pkg::status_type          status;
   logic [opl_pkg::WORD_W-1:0]   read_word;
   logic [opl_pkg::RPOS_W-1:0]   result_position;
   logic [opl_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output read_word, output result_position,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input read_word, input result_position,
                   input entry_count, output ready);
endinterface

// File: rtl/opl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module opl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/opl_datapath.sv
// Datapath of the ordered pointer list: entry RAM, count, walk pointer, result and
// response registers. Driven by opl_ctrl commands. Depends on opl_pkg, opl_ifs, opl_ram.
module opl_datapath #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  opl_pkg::cmd_type             cmd,
   output opl_pkg::sts_type             sts,
   input  logic [opl_pkg::OP_W-1:0]     req_op,
   input  logic [opl_pkg::POS_W-1:0]    req_position,
   input  logic [opl_pkg::WORD_W-1:0]   req_data_word,
   opl_rsp_if.source                    rsp
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [opl_pkg::WORD_W-1:0]   word_ff, word_in;
   logic                         ret_valid_ff, ret_valid_in;
   logic [AW-1:0]                ret_idx_ff, ret_idx_in;
   opl_pkg::status_type          status_ff, status_in;
   logic [opl_pkg::WORD_W-1:0]   rword_ff, rword_in;
   logic [AW-1:0]                rpos_ff, rpos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   opl_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [opl_pkg::WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [opl_pkg::RPOS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [opl_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                         pos_ge_count;
   logic                         pos_ge_max;
   logic                         list_full;
   logic [CW-1:0]                clamp_idx;
   opl_pkg::status_type          load_status;
   logic [CW-1:0]                rd_idx;
   logic [AW-1:0]                rd_addr;
   logic [opl_pkg::WORD_W-1:0]   rd_data;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [opl_pkg::WORD_W-1:0]   wr_data;
   logic                         idx_eq_pos;
   logic                         match;

   opl_ram #(
      .WIDTH (opl_pkg::WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      pos_ge_count = req_position >= opl_pkg::POS_W'(count_ff);
      pos_ge_max   = req_position >= opl_pkg::POS_W'(MAX_ENTRIES);
      list_full    = count_ff == CW'(MAX_ENTRIES);
      clamp_idx    = pos_ge_count ? count_ff : CW'(req_position);
      case (req_op)
         opl_pkg::OP_INSERT: begin
            load_status = list_full ? opl_pkg::ST_FULL : opl_pkg::ST_OK;
         end
         opl_pkg::OP_DELETE, opl_pkg::OP_GET: begin
            load_status = pos_ge_count ? opl_pkg::ST_RANGE : opl_pkg::ST_OK;
         end
         opl_pkg::OP_SET: begin
            load_status = pos_ge_max ? opl_pkg::ST_RANGE : opl_pkg::ST_OK;
         end
         opl_pkg::OP_FIND: begin
            load_status = opl_pkg::ST_NOTFOUND;
         end
         default: begin
            load_status = opl_pkg::ST_OK;
         end
      endcase
   end

   assign rd_idx     = cmd.down ? idx_ff - CW'(1) : idx_ff;
   assign rd_addr    = AW'(rd_idx);
   assign idx_eq_pos = idx_ff == CW'(pos_ff);
   assign match      = ret_valid_ff && (rd_data == word_ff);

   always_comb begin
      sts.op           = req_op;
      sts.req_skip     = (req_op == opl_pkg::OP_FIND) ? (count_ff == '0)
                                                      : (load_status != opl_pkg::ST_OK);
      sts.idx_eq_pos   = idx_eq_pos;
      sts.idx_eq_count = idx_ff == count_ff;
      sts.match        = match;
      sts.last_miss    = ret_valid_ff && !match
                         && ((CW'(ret_idx_ff) + CW'(1)) == count_ff);
      sts.out_free     = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = word_ff;
      case (cmd.wr)
         opl_pkg::WR_UP: begin
            wr_en   = ret_valid_ff;
            wr_addr = ret_idx_ff + AW'(1);
            wr_data = rd_data;
         end
         opl_pkg::WR_DOWN: begin
            wr_en   = ret_valid_ff && (ret_idx_ff != pos_ff);
            wr_addr = ret_idx_ff - AW'(1);
            wr_data = rd_data;
         end
         opl_pkg::WR_FILL: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff);
            wr_data = idx_eq_pos ? word_ff : '0;
         end
         opl_pkg::WR_WORD: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      ret_valid_in  = cmd.rd;
      ret_idx_in    = rd_addr;
      status_in     = status_ff;
      rword_in      = rword_ff;
      rpos_in       = rpos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.load) begin
         word_in   = req_data_word;
         status_in = load_status;
         rword_in  = '0;
         rpos_in   = '0;
         case (req_op)
            opl_pkg::OP_INSERT: begin
               idx_in = count_ff;
               pos_in = AW'(clamp_idx);
               if (!list_full) begin
                  rpos_in = AW'(clamp_idx);
               end
            end
            opl_pkg::OP_SET: begin
               idx_in = clamp_idx;
               pos_in = AW'(req_position);
            end
            opl_pkg::OP_FIND: begin
               idx_in = '0;
            end
            opl_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               idx_in = CW'(req_position);
               pos_in = AW'(req_position);
            end
         endcase
      end

      if (cmd.step) begin
         idx_in = cmd.down ? idx_ff - CW'(1) : idx_ff + CW'(1);
      end

      if (cmd.capture && ret_valid_ff && (ret_idx_ff == pos_ff)) begin
         rword_in = rd_data;
      end

      if (cmd.find && match) begin
         status_in = opl_pkg::ST_OK;
         rpos_in   = ret_idx_ff;
      end

      case (cmd.cnt)
         opl_pkg::CNT_INC: begin
            count_in = count_ff + CW'(1);
         end
         opl_pkg::CNT_DEC: begin
            count_in = count_ff - CW'(1);
         end
         opl_pkg::CNT_EXTEND: begin
            if (CW'(pos_ff) >= count_ff) begin
               count_in = CW'(pos_ff) + CW'(1);
            end
         end
         default: begin
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_word_in   = rword_ff;
         rsp_pos_in    = opl_pkg::RPOS_W'(rpos_ff);
         rsp_count_in  = opl_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ret_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ret_valid_ff <= ret_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      ret_idx_ff    <= ret_idx_in;
      status_ff     <= status_in;
      rword_ff      <= rword_in;
      rpos_ff       <= rpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.read_word       = rsp_word_ff;
   assign rsp.result_position = rsp_pos_ff;
   assign rsp.entry_count     = rsp_count_ff;

endmodule

// File: rtl/opl_ctrl.sv
// Controller of the ordered pointer list: sequences the entry walks of each request.
// Depends on opl_pkg.
module opl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  opl_pkg::sts_type  sts,
   output opl_pkg::cmd_type  cmd
);

   opl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= opl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.wr      = opl_pkg::WR_NONE;
      cmd.cnt     = opl_pkg::CNT_HOLD;
      case (state_ff)
         opl_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_skip) begin
                  state_in = opl_pkg::S_FINISH;
               end else begin
                  case (sts.op)
                     opl_pkg::OP_INSERT: state_in = opl_pkg::S_INS_SHIFT;
                     opl_pkg::OP_DELETE: state_in = opl_pkg::S_DEL_WALK;
                     opl_pkg::OP_GET:    state_in = opl_pkg::S_GET_READ;
                     opl_pkg::OP_SET:    state_in = opl_pkg::S_SET_FILL;
                     opl_pkg::OP_FIND:   state_in = opl_pkg::S_FIND_WALK;
                     default:            state_in = opl_pkg::S_FINISH;
                  endcase
               end
            end
         end
         opl_pkg::S_INS_SHIFT: begin
            cmd.wr   = opl_pkg::WR_UP;
            cmd.down = 1'b1;
            if (sts.idx_eq_pos) begin
               state_in = opl_pkg::S_INS_WRITE;
            end else begin
               cmd.rd   = 1'b1;
               cmd.step = 1'b1;
            end
         end
         opl_pkg::S_INS_WRITE: begin
            cmd.wr   = opl_pkg::WR_WORD;
            cmd.cnt  = opl_pkg::CNT_INC;
            state_in = opl_pkg::S_FINISH;
         end
         opl_pkg::S_DEL_WALK: begin
            cmd.wr      = opl_pkg::WR_DOWN;
            cmd.capture = 1'b1;
            if (sts.idx_eq_count) begin
               cmd.cnt  = opl_pkg::CNT_DEC;
               state_in = opl_pkg::S_FINISH;
            end else begin
               cmd.rd   = 1'b1;
               cmd.step = 1'b1;
            end
         end
         opl_pkg::S_GET_READ: begin
            cmd.rd   = 1'b1;
            state_in = opl_pkg::S_GET_WAIT;
         end
         opl_pkg::S_GET_WAIT: begin
            cmd.capture = 1'b1;
            state_in    = opl_pkg::S_FINISH;
         end
         opl_pkg::S_SET_FILL: begin
            cmd.wr = opl_pkg::WR_FILL;
            if (sts.idx_eq_pos) begin
               cmd.cnt  = opl_pkg::CNT_EXTEND;
               state_in = opl_pkg::S_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         opl_pkg::S_FIND_WALK: begin
            cmd.find = 1'b1;
            if (sts.match || sts.last_miss) begin
               state_in = opl_pkg::S_FINISH;
            end else if (!sts.idx_eq_count) begin
               cmd.rd   = 1'b1;
               cmd.step = 1'b1;
            end
         end
         opl_pkg::S_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = opl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = opl_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/ordered_pointer_list.sv
// Ordered list of up to MAX_ENTRIES 32-bit words with insert, delete, get, set,
// find and clear. One request is worked at a time; the entry RAM has one read and
// one write port and a walk moves one entry per cycle. Set zero-fills the entries
// between the end of the list and the set position, and find stops at the first
// match. Clear and rejected requests skip the walk. The next request is accepted
// while the response register still waits to be taken. No clearing pass after
// reset.
// Depends on opl_pkg, opl_ifs, opl_ctrl, opl_datapath.
module ordered_pointer_list #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic      clock,
   input  logic      reset,
   opl_req_if.sink   req_bus,
   opl_rsp_if.source rsp_bus
);

   opl_pkg::cmd_type cmd;
   opl_pkg::sts_type sts;
   logic             req_ready;

   opl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   opl_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_bus.op),
      .req_position  (req_bus.position),
      .req_data_word (req_bus.data_word),
      .rsp           (rsp_bus)
   );

   assign req_bus.ready = req_ready;

`ifndef SYNTHESIS
   a_busy_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_bus.ready)
      else $error("request accepted while a previous one is in progress");

   a_emit_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_bus.valid)
      else $error("response not presented after completion");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.rd, cmd.emit}))
      else $error("load, read and emit overlap");

   a_error_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status != opl_pkg::ST_OK)
      |-> (rsp_bus.read_word == '0) && (rsp_bus.result_position == '0))
      else $error("failed request returns data");
`endif

endmodule
